// ===== design/integer_literal_parser_assert.svh =====
// Assertion macros shared by the integer literal parser modules.
// Expect clk and rst_n in the scope where the macros are used.
`ifndef INTEGER_LITERAL_PARSER_ASSERT_SVH
`define INTEGER_LITERAL_PARSER_ASSERT_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define ILP_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define ILP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/ilp_pkg.sv =====
// Package for the integer literal parser: codes, character constants,
// the hand-off struct between stages and the digit helper functions.
package ilp_pkg;

    typedef enum logic [1:0] {
        PH_FIRST  = 2'd0,
        PH_LEAD0  = 2'd1,
        PH_DIGITS = 2'd2,
        PH_SUFFIX = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        RADIX_DEC = 2'd0,
        RADIX_HEX = 2'd1,
        RADIX_OCT = 2'd2,
        RADIX_BIN = 2'd3
    } radix_t;

    typedef enum logic [1:0] {
        ELL_NONE  = 2'd0,
        ELL_LOWER = 2'd1,
        ELL_UPPER = 2'd2
    } ell_t;

    typedef enum logic [1:0] {
        ERR_NONE   = 2'd0,
        ERR_BASE   = 2'd1,
        ERR_SUFFIX = 2'd2,
        ERR_RANGE  = 2'd3
    } err_t;

    typedef enum logic [2:0] {
        TC_INT    = 3'd0,
        TC_UINT   = 3'd1,
        TC_LONG   = 3'd2,
        TC_ULONG  = 3'd3,
        TC_LLONG  = 3'd4,
        TC_ULLONG = 3'd5
    } tcode_t;

    localparam int PF_UNS  = 0;
    localparam int PF_SGN  = 1;
    localparam int PF_INT  = 2;
    localparam int PF_LONG = 3;
    localparam logic [3:0] PF_RESET = 4'b1110;

    localparam logic [7:0] CH_0    = 8'h30;
    localparam logic [7:0] CH_1    = 8'h31;
    localparam logic [7:0] CH_9    = 8'h39;
    localparam logic [7:0] CH_A_UC = 8'h41;
    localparam logic [7:0] CH_F_UC = 8'h46;
    localparam logic [7:0] CH_A_LC = 8'h61;
    localparam logic [7:0] CH_F_LC = 8'h66;
    localparam logic [7:0] CH_X_LC = 8'h78;
    localparam logic [7:0] CH_X_UC = 8'h58;
    localparam logic [7:0] CH_B_LC = 8'h62;
    localparam logic [7:0] CH_B_UC = 8'h42;
    localparam logic [7:0] CH_L_LC = 8'h6C;
    localparam logic [7:0] CH_L_UC = 8'h4C;
    localparam logic [7:0] CH_U_LC = 8'h75;
    localparam logic [7:0] CH_U_UC = 8'h55;

    localparam logic [4:0] DIGIT_NONE = 5'd31;

    typedef struct packed {
        logic [63:0] accum;
        logic [3:0]  permit;
        err_t        err;
    } fin_t;

    function automatic logic [4:0] digit_value(input logic [7:0] c);
        logic [4:0] d;
        d = DIGIT_NONE;
        if (c >= CH_0 && c <= CH_9)
        begin
            d = 5'(c - CH_0);
        end
        else if (c >= CH_A_LC && c <= CH_F_LC)
        begin
            d = 5'(c - CH_A_LC + 8'd10);
        end
        else if (c >= CH_A_UC && c <= CH_F_UC)
        begin
            d = 5'(c - CH_A_UC + 8'd10);
        end
        return d;
    endfunction

    function automatic logic [4:0] radix_base(input radix_t r);
        logic [4:0] b;
        unique case (r)
            RADIX_DEC: b = 5'd10;
            RADIX_HEX: b = 5'd16;
            RADIX_OCT: b = 5'd8;
            RADIX_BIN: b = 5'd2;
            default:   b = 5'd10;
        endcase
        return b;
    endfunction

endpackage

// ===== design/ilp_in_if.sv =====
// Character channel of the integer literal parser: one character word
// with its last mark. Stands alone; no package needed.
interface ilp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;
    logic       last;

    modport source (output valid, output ch, output last, input ready);
    modport sink   (input valid, input ch, input last, output ready);
endinterface

// ===== design/ilp_out_if.sv =====
// Result channel of the integer literal parser: value, type code and
// error code word. Stands alone; no package needed.
interface ilp_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] value;
    logic [2:0]  type_code;
    logic [1:0]  error_code;

    modport source (output valid, output value, output type_code, output error_code,
                    input ready);
    modport sink   (input valid, input value, input type_code, input error_code,
                    output ready);
endinterface

// ===== design/ilp_scan.sv =====
// Character scanner: parser state registers and the literal-end register.
// Depends on ilp_pkg, ilp_in_if and integer_literal_parser_assert.svh.
`include "integer_literal_parser_assert.svh"

module ilp_scan (
    input  logic          clk,
    input  logic          rst_n,
    ilp_in_if.sink        chars,
    output logic          fin_valid,
    input  logic          fin_ready,
    output ilp_pkg::fin_t fin
);

    ilp_pkg::phase_t phase_reg, phase_next;
    ilp_pkg::radix_t radix_reg, radix_next;
    logic [63:0]     accum_reg, accum_next;
    logic [3:0]      permit_reg, permit_next;
    ilp_pkg::ell_t   pend_reg, pend_next;
    ilp_pkg::err_t   err_reg, err_next;
    logic            fin_valid_reg, fin_valid_next;
    ilp_pkg::fin_t   fin_reg, fin_next;

    logic            take;
    logic [4:0]      dval;
    logic            prefix_x;
    logic            prefix_b;
    logic            is_digit;
    logic            is_ell;
    logic            is_u;
    ilp_pkg::ell_t   ell_code;
    logic [63:0]     scaled;
    logic [63:0]     accum_step;
    logic [3:0]      suf_permit;
    ilp_pkg::ell_t   suf_pend;
    ilp_pkg::err_t   suf_err;
    logic [3:0]      fin_permit;

    assign chars.ready = !fin_valid_reg || fin_ready;
    assign take        = chars.valid && chars.ready;
    assign fin_valid   = fin_valid_reg;
    assign fin         = fin_reg;

    assign dval     = ilp_pkg::digit_value(chars.ch);
    assign is_digit = dval < ilp_pkg::radix_base(radix_reg);
    assign prefix_x = chars.ch == ilp_pkg::CH_X_LC || chars.ch == ilp_pkg::CH_X_UC;
    assign prefix_b = chars.ch == ilp_pkg::CH_B_LC || chars.ch == ilp_pkg::CH_B_UC;
    assign is_ell   = chars.ch == ilp_pkg::CH_L_LC || chars.ch == ilp_pkg::CH_L_UC;
    assign is_u     = chars.ch == ilp_pkg::CH_U_LC || chars.ch == ilp_pkg::CH_U_UC;
    assign ell_code = (chars.ch == ilp_pkg::CH_L_LC) ? ilp_pkg::ELL_LOWER
                                                     : ilp_pkg::ELL_UPPER;

    always_comb
    begin
        unique case (radix_reg)
            ilp_pkg::RADIX_DEC: scaled = (accum_reg << 3) + (accum_reg << 1);
            ilp_pkg::RADIX_HEX: scaled = accum_reg << 4;
            ilp_pkg::RADIX_OCT: scaled = accum_reg << 3;
            ilp_pkg::RADIX_BIN: scaled = accum_reg << 1;
            default:            scaled = accum_reg;
        endcase
        accum_step = scaled + {59'd0, dval};
    end

    // Suffix character effect on the type permissions
    always_comb
    begin
        suf_permit = permit_reg;
        suf_pend   = ilp_pkg::ELL_NONE;
        suf_err    = ilp_pkg::ERR_NONE;
        if (is_ell)
        begin
            if (pend_reg == ell_code)
            begin
                suf_permit[ilp_pkg::PF_INT]  = 1'b0;
                suf_permit[ilp_pkg::PF_LONG] = 1'b0;
            end
            else
            begin
                if (pend_reg != ilp_pkg::ELL_NONE)
                begin
                    suf_permit[ilp_pkg::PF_INT] = 1'b0;
                end
                suf_pend = ell_code;
            end
        end
        else
        begin
            if (pend_reg != ilp_pkg::ELL_NONE)
            begin
                suf_permit[ilp_pkg::PF_INT] = 1'b0;
            end
            if (is_u)
            begin
                suf_permit[ilp_pkg::PF_UNS] = 1'b1;
                suf_permit[ilp_pkg::PF_SGN] = 1'b0;
            end
            else
            begin
                suf_err = ilp_pkg::ERR_SUFFIX;
            end
        end
    end

    always_comb
    begin
        phase_next     = phase_reg;
        radix_next     = radix_reg;
        accum_next     = accum_reg;
        permit_next    = permit_reg;
        pend_next      = pend_reg;
        err_next       = err_reg;
        fin_next       = fin_reg;
        fin_permit     = permit_reg;
        fin_valid_next = fin_valid_reg && !fin_ready;

        if (take && err_reg == ilp_pkg::ERR_NONE)
        begin
            unique case (phase_reg)
                ilp_pkg::PH_FIRST:
                begin
                    if (chars.ch == ilp_pkg::CH_0)
                    begin
                        radix_next                   = ilp_pkg::RADIX_OCT;
                        permit_next[ilp_pkg::PF_UNS] = 1'b1;
                        accum_next                   = 64'd0;
                        phase_next                   = ilp_pkg::PH_LEAD0;
                    end
                    else if (chars.ch >= ilp_pkg::CH_1 && chars.ch <= ilp_pkg::CH_9)
                    begin
                        radix_next = ilp_pkg::RADIX_DEC;
                        accum_next = {60'd0, chars.ch[3:0]};
                        phase_next = ilp_pkg::PH_DIGITS;
                    end
                    else
                    begin
                        err_next = ilp_pkg::ERR_BASE;
                    end
                end
                ilp_pkg::PH_LEAD0, ilp_pkg::PH_DIGITS:
                begin
                    phase_next = ilp_pkg::PH_DIGITS;
                    if (phase_reg == ilp_pkg::PH_LEAD0 && prefix_x)
                    begin
                        radix_next = ilp_pkg::RADIX_HEX;
                    end
                    else if (phase_reg == ilp_pkg::PH_LEAD0 && prefix_b)
                    begin
                        radix_next = ilp_pkg::RADIX_BIN;
                    end
                    else if (is_digit)
                    begin
                        accum_next = accum_step;
                    end
                    else
                    begin
                        phase_next  = ilp_pkg::PH_SUFFIX;
                        permit_next = suf_permit;
                        pend_next   = suf_pend;
                        err_next    = suf_err;
                    end
                end
                ilp_pkg::PH_SUFFIX:
                begin
                    permit_next = suf_permit;
                    pend_next   = suf_pend;
                    err_next    = suf_err;
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
        end

        if (take && chars.last)
        begin
            // Close an unpaired ell, hand off, and restart for the next literal
            fin_permit = permit_next;
            if (err_next == ilp_pkg::ERR_NONE && pend_next != ilp_pkg::ELL_NONE)
            begin
                fin_permit[ilp_pkg::PF_INT] = 1'b0;
            end
            fin_next.accum  = accum_next;
            fin_next.permit = fin_permit;
            fin_next.err    = err_next;
            fin_valid_next  = 1'b1;

            phase_next  = ilp_pkg::PH_FIRST;
            radix_next  = ilp_pkg::RADIX_DEC;
            accum_next  = 64'd0;
            permit_next = ilp_pkg::PF_RESET;
            pend_next   = ilp_pkg::ELL_NONE;
            err_next    = ilp_pkg::ERR_NONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= ilp_pkg::PH_FIRST;
            radix_reg     <= ilp_pkg::RADIX_DEC;
            accum_reg     <= 64'd0;
            permit_reg    <= ilp_pkg::PF_RESET;
            pend_reg      <= ilp_pkg::ELL_NONE;
            err_reg       <= ilp_pkg::ERR_NONE;
            fin_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            radix_reg     <= radix_next;
            accum_reg     <= accum_next;
            permit_reg    <= permit_next;
            pend_reg      <= pend_next;
            err_reg       <= err_next;
            fin_valid_reg <= fin_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fin_reg <= fin_next;
    end

    `ILP_ASSERT_NEXT(a_restart_after_last, take && chars.last, phase_reg == ilp_pkg::PH_FIRST && err_reg == ilp_pkg::ERR_NONE && pend_reg == ilp_pkg::ELL_NONE, "scanner did not restart after last word")
    `ILP_ASSERT_NEXT(a_fin_held, fin_valid_reg && !fin_ready, fin_valid_reg && $stable(fin_reg), "pending literal dropped or changed")
    `ILP_ASSERT_NEXT(a_error_sticks, take && !chars.last && err_reg != ilp_pkg::ERR_NONE, err_reg == $past(err_reg), "sticky error changed mid-literal")

endmodule

// ===== design/ilp_classify.sv =====
// Type selector and result register for the integer literal parser.
// Depends on ilp_pkg, ilp_out_if and integer_literal_parser_assert.svh.
`include "integer_literal_parser_assert.svh"

module ilp_classify (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          fin_valid,
    output logic          fin_ready,
    input  ilp_pkg::fin_t fin,
    ilp_out_if.source     results
);

    logic            out_valid_reg, out_valid_next;
    logic [63:0]     value_reg, value_next;
    ilp_pkg::tcode_t type_reg, type_next;
    ilp_pkg::err_t   err_reg, err_next;

    logic            load;
    logic            fits_int;
    logic            fits_uint;
    logic            fits_long;
    logic            uns;
    logic            sgn;
    logic            in_int;
    logic            in_long;

    assign fin_ready = !out_valid_reg || results.ready;
    assign load      = fin_valid && fin_ready;

    assign fits_int  = fin.accum[63:31] == 33'd0;
    assign fits_uint = fin.accum[63:32] == 32'd0;
    assign fits_long = !fin.accum[63];
    assign uns       = fin.permit[ilp_pkg::PF_UNS];
    assign sgn       = fin.permit[ilp_pkg::PF_SGN];
    assign in_int    = fin.permit[ilp_pkg::PF_INT];
    assign in_long   = fin.permit[ilp_pkg::PF_LONG];

    always_comb
    begin
        out_valid_next = out_valid_reg && !results.ready;
        value_next     = value_reg;
        type_next      = type_reg;
        err_next       = err_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
            value_next     = fin.accum;
            type_next      = ilp_pkg::TC_INT;
            err_next       = fin.err;
            if (fin.err != ilp_pkg::ERR_NONE)
            begin
                value_next = 64'd0;
            end
            else
            begin
                priority if (fits_int && in_int && sgn)
                begin
                    type_next = ilp_pkg::TC_INT;
                end
                else if (fits_uint && in_int && uns)
                begin
                    type_next = ilp_pkg::TC_UINT;
                end
                else if (fits_long && in_long && sgn)
                begin
                    type_next = ilp_pkg::TC_LONG;
                end
                else if (in_long && uns)
                begin
                    type_next = ilp_pkg::TC_ULONG;
                end
                else if (fits_long && sgn)
                begin
                    type_next = ilp_pkg::TC_LLONG;
                end
                else if (uns)
                begin
                    type_next = ilp_pkg::TC_ULLONG;
                end
                else
                begin
                    err_next   = ilp_pkg::ERR_RANGE;
                    value_next = 64'd0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        type_reg  <= type_next;
        err_reg   <= err_next;
    end

    assign results.valid      = out_valid_reg;
    assign results.value      = value_reg;
    assign results.type_code  = type_reg;
    assign results.error_code = err_reg;

    `ILP_ASSERT_SAME(a_error_zeroes, out_valid_reg && err_reg != ilp_pkg::ERR_NONE, value_reg == 64'd0 && type_reg == ilp_pkg::TC_INT, "error word carries value or type")
    `ILP_ASSERT_NEXT(a_load_shows, load, out_valid_reg, "loaded literal not presented")
    `ILP_ASSERT_SAME(a_range_ok, out_valid_reg && type_reg == ilp_pkg::TC_INT, value_reg[63:31] == 33'd0, "int word out of range")

endmodule

// ===== design/integer_literal_parser.sv =====
// A literal's result is registered in the literal-end register, then in the result register.
// Throughput: one character word per cycle while the output is not stalled; literals may follow back to back.
// The result register and the literal-end register decouple input from a stalled output.
// Reset clears the scanner to its first-character state and empties both registers.
// Top level of the integer literal parser; depends on ilp_pkg, the channel interfaces,
// ilp_scan and ilp_classify.
module integer_literal_parser (
    input  logic      clk,
    input  logic      rst_n,
    ilp_in_if.sink    chars,
    ilp_out_if.source results
);

    logic          fin_valid;
    logic          fin_ready;
    ilp_pkg::fin_t fin;

    ilp_scan u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .chars     (chars),
        .fin_valid (fin_valid),
        .fin_ready (fin_ready),
        .fin       (fin)
    );

    ilp_classify u_classify (
        .clk       (clk),
        .rst_n     (rst_n),
        .fin_valid (fin_valid),
        .fin_ready (fin_ready),
        .fin       (fin),
        .results   (results)
    );

endmodule
